@@ design/dkscan_pkg.sv @@
package dkscan_pkg;

	localparam int ROW_COUNT    = 4;
	localparam int ROW_IDX_BITS = $clog2(ROW_COUNT);
	localparam int ELAPSED_BITS = 20;
	localparam int TICKS_BITS   = 20;
	localparam int CMP_BITS     = (ELAPSED_BITS > TICKS_BITS) ? ELAPSED_BITS : TICKS_BITS;
	localparam int COLUMN_COUNT = 3;

	localparam logic [TICKS_BITS-1:0] TICKS_RESET = TICKS_BITS'(100000);

	typedef logic [ELAPSED_BITS-1:0] elapsed_t;
	typedef logic [1:0]              column_t;

	localparam column_t COL_NONE  = 2'd0;
	localparam column_t COL_FIRST = 2'd1;
	localparam column_t COL_LAST  = 2'd3;

	localparam column_t SCAN_FIRST = 2'd0;
	localparam column_t SCAN_LAST  = 2'd2;

	localparam logic [2:0] DRIVE_NONE = 3'b111;

	function automatic logic [3:0] key_map(input column_t col_idx,
			input logic [ROW_IDX_BITS-1:0] row_idx);
		logic [3:0] code;
		code = 4'd0;
		unique case (col_idx)
			2'd0: begin
				unique case (row_idx)
					2'd0: code = 4'd1;
					2'd1: code = 4'd4;
					2'd2: code = 4'd7;
					default: code = 4'd10;
				endcase
			end
			2'd1: begin
				unique case (row_idx)
					2'd0: code = 4'd2;
					2'd1: code = 4'd5;
					2'd2: code = 4'd8;
					default: code = 4'd0;
				endcase
			end
			2'd2: begin
				unique case (row_idx)
					2'd0: code = 4'd3;
					2'd1: code = 4'd6;
					2'd2: code = 4'd9;
					default: code = 4'd12;
				endcase
			end
			default: code = 4'd0;
		endcase
		return code;
	endfunction

endpackage

@@ design/debounced_keypad_scanner_4x3_core.sv @@
// channel  direction  handshake            payload
// in       input      in_valid / in_ready  row_levels
// out      output     out_valid/out_ready  column_drive, key_valid, key_code, locked_column
// cfg      input      cfg_wr_en            cfg_wr_data (debounce_ticks)
//
// One item per cycle while the result register is not stalled: an item sits in the
// input register, where the four per-row debouncers and the scan logic update, and
// then waits in the result register.
// Reset releases all rows, starts each debouncer counting and scans from column 1.
// A stalled result register holds the input stage; input is taken whenever the result
// register is free or being emptied in the same cycle.
module debounced_keypad_scanner_4x3_core import dkscan_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [3:0]            row_levels,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            column_drive,
	output logic                  key_valid,
	output logic [3:0]            key_code,
	output logic [1:0]            locked_column,
	input  logic                  cfg_wr_en,
	input  logic [TICKS_BITS-1:0] cfg_wr_data
);

	logic [TICKS_BITS-1:0] ticks_q;

	logic                valid_s1;
	logic [ROW_COUNT-1:0] rows_s1;

	logic [ROW_COUNT-1:0] level_q, level_d;
	logic [ROW_COUNT-1:0] settled_q, settled_d;
	elapsed_t             elapsed_q [ROW_COUNT];
	elapsed_t             elapsed_d [ROW_COUNT];
	elapsed_t             elapsed_inc [ROW_COUNT];
	column_t              scan_q, scan_d;
	column_t              held_q, held_d;

	logic                    out_valid_q;
	logic [2:0]              drive_q;
	logic                    key_valid_q;
	logic [3:0]              key_code_q;
	column_t                 locked_q;

	logic                    out_free;
	logic                    advance;
	logic [2:0]              drive;
	logic                    fresh_low;
	logic                    done_found;
	logic [ROW_IDX_BITS-1:0] done_row;
	logic                    report;
	logic [3:0]              code;

	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_comb begin
		if (held_q != COL_NONE) begin
			drive = ~(3'b001 << (held_q - COL_FIRST));
		end else if (scan_q <= SCAN_LAST) begin
			drive = ~(3'b001 << scan_q);
		end else begin
			drive = DRIVE_NONE;
		end
	end

	always_comb begin
		level_d    = level_q;
		settled_d  = settled_q;
		fresh_low  = 1'b0;
		done_found = 1'b0;
		done_row   = '0;
		for (int r = 0; r < ROW_COUNT; r++) begin
			elapsed_inc[r] = (elapsed_q[r] != '1) ? elapsed_q[r] + elapsed_t'(1) : elapsed_q[r];
			elapsed_d[r]   = elapsed_q[r];
			if (!settled_q[r]) begin
				elapsed_d[r] = elapsed_inc[r];
				if (CMP_BITS'(elapsed_inc[r]) >= CMP_BITS'(ticks_q) || elapsed_inc[r] == '1) begin
					settled_d[r] = 1'b1;
					if (!level_q[r] && !done_found) begin
						done_found = 1'b1;
						done_row   = ROW_IDX_BITS'(r);
					end
				end
			end else if (rows_s1[r] != level_q[r]) begin
				level_d[r]   = rows_s1[r];
				settled_d[r] = 1'b0;
				elapsed_d[r] = '0;
			end
			if (!settled_d[r] && !level_d[r]) begin
				fresh_low = 1'b1;
			end
		end
	end

	always_comb begin
		held_d = held_q;
		scan_d = scan_q;
		if (held_q == COL_NONE) begin
			if (fresh_low && scan_q <= SCAN_LAST) begin
				held_d = scan_q + COL_FIRST;
			end else begin
				scan_d = (scan_q >= SCAN_LAST) ? SCAN_FIRST : scan_q + 2'd1;
			end
		end
		report = (held_d != COL_NONE) && done_found;
		code   = report ? key_map(held_d - COL_FIRST, done_row) : 4'd0;
		if (report) begin
			held_d = COL_NONE;
			scan_d = SCAN_FIRST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= TICKS_RESET;
		end else if (cfg_wr_en) begin
			ticks_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rows_s1 <= row_levels;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= '1;
			settled_q <= '0;
			for (int r = 0; r < ROW_COUNT; r++) begin
				elapsed_q[r] <= '0;
			end
			scan_q <= SCAN_FIRST;
			held_q <= COL_NONE;
		end else if (advance) begin
			level_q   <= level_d;
			settled_q <= settled_d;
			for (int r = 0; r < ROW_COUNT; r++) begin
				elapsed_q[r] <= elapsed_d[r];
			end
			scan_q <= scan_d;
			held_q <= held_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_q     <= drive;
			key_valid_q <= report;
			key_code_q  <= code;
			locked_q    <= held_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign column_drive  = drive_q;
	assign key_valid     = key_valid_q;
	assign key_code      = key_code_q;
	assign locked_column = locked_q;

`ifndef SYNTHESIS
	a_report_unlocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && key_valid_q |-> locked_q == COL_NONE)
		else $error("reported item still shows a locked column");

	a_code_zero_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !key_valid_q |-> key_code_q == 4'd0)
		else $error("key code nonzero without a report");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q != 2'd3)
		else $error("scan column out of range");

	a_one_column: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $countones(drive_q) == 2)
		else $error("column drive does not ground exactly one column");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> $stable(held_q) && $stable(scan_q))
		else $error("scan state moved while result register stalled");
`endif

endmodule
